// File: hw/rtl/perceptron_sum_and_update_defines.svh
// assertion macros used by psu_wmem and perceptron_sum_and_update, clocked on clk_i and gated by rst_ni
`ifndef PERCEPTRON_SUM_AND_UPDATE_DEFINES_SVH
`define PERCEPTRON_SUM_AND_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
`define PSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psu assertion failed");
`define PSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psu implication failed");
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psu next-cycle check failed");
`else
`define PSU_ASSERT(lbl, prop)
`define PSU_ASSERT_IMP(lbl, ante, cons)
`define PSU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/psu_pkg.sv
`default_nettype none

package psu_pkg;

  localparam int FEATURES = 16;
  localparam int DEPTH    = FEATURES + 1;
  localparam int AW       = $clog2(DEPTH);

  localparam int X_W    = 16;
  localparam int LR_W   = 16;
  localparam int W_W    = 32;
  localparam int ACC_W  = 48;
  localparam int P1_W   = LR_W + X_W + 1;
  localparam int FRAC_W = 16;

  localparam logic [LR_W-1:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [X_W-1:0]  BIAS_INPUT_RST = 16'd256;
  localparam logic [ACC_W:0]  RND_HALF       = (ACC_W + 1)'(1) << (FRAC_W - 1);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
  localparam logic [W_W-1:0]   W_MAX   = {1'b0, {(W_W - 1){1'b1}}};
  localparam logic [W_W-1:0]   W_MIN   = {1'b1, {(W_W - 1){1'b0}}};

  typedef enum logic [0:0] {
    REG_LEARN_RATE = 1'b0,
    REG_BIAS_INPUT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CMD_EVAL = 1'b0,
    CMD_CORR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic p1_load;
    logic mul;
    logic upd;
    logic corr;
    logic row_clr;
  } dp_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/psu_wmem.sv
`default_nettype none
`include "perceptron_sum_and_update_defines.svh"

module psu_wmem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         re_i,
  input  logic [psu_pkg::AW-1:0]       raddr_i,
  input  logic                         we_i,
  input  logic [psu_pkg::AW-1:0]       waddr_i,
  input  logic [psu_pkg::W_W-1:0]      wdata_i,
  output logic [psu_pkg::W_W-1:0]      rdata_o
);
  import psu_pkg::*;

  logic [W_W-1:0]   mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [W_W-1:0]   rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // an entry never written since reset reads as zero
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

  `PSU_ASSERT_IMP(a_no_rw_same_entry, re_i && we_i, raddr_i != waddr_i)
  `PSU_ASSERT_NEXT(a_valid_after_write, we_i, valid_q[$past(waddr_i)])
  `PSU_ASSERT_NEXT(a_unwritten_reads_zero, re_i && !valid_q[raddr_i], rdata_o == '0)

endmodule

`default_nettype wire

// File: hw/rtl/psu_dp.sv
`default_nettype none

module psu_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psu_pkg::dp_ctrl_t           ctrl_i,
  input  logic [psu_pkg::LR_W-1:0]    lr_i,
  input  logic [psu_pkg::X_W-1:0]     err_i,
  input  logic [psu_pkg::X_W-1:0]     x_i,
  input  logic [psu_pkg::W_W-1:0]     w_i,
  output logic [psu_pkg::W_W-1:0]     wdata_o,
  output logic [psu_pkg::ACC_W-1:0]   acc_o,
  output logic                        sat_o
);
  import psu_pkg::*;

  logic [P1_W-1:0]        p1_q;
  logic [P1_W-1:0]        mul_a;
  logic [P1_W+X_W-1:0]    mul_full;
  logic [ACC_W-1:0]       prod_q;
  logic [W_W-1:0]         w_q;

  logic [ACC_W:0]         sum;
  logic                   acc_ovf;
  logic [ACC_W-1:0]       acc_sat;
  logic [ACC_W:0]         rnd;
  logic [ACC_W-FRAC_W:0]  delta;
  logic [W_W+1:0]         wsum;
  logic                   w_ovf;

  logic [ACC_W-1:0]       acc_d, acc_q;
  logic                   sat_d, sat_q;

  // learn_rate * error, taken straight from the accepted beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.p1_load) begin
      p1_q <= $signed({1'b0, lr_i}) * $signed(err_i);
    end
  end

  // one shared multiplier: eta*err*x on correct, w*x on evaluate
  assign mul_a    = ctrl_i.corr ? p1_q : {w_i[W_W-1], w_i};
  assign mul_full = $signed(mul_a) * $signed(x_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= mul_full[ACC_W-1:0];
      w_q    <= w_i;
    end
  end

  assign sum     = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
  assign acc_ovf = sum[ACC_W] ^ sum[ACC_W-1];
  assign acc_sat = acc_ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  // round half up, then floor shift back to q16.16
  assign rnd   = {prod_q[ACC_W-1], prod_q} + RND_HALF;
  assign delta = rnd[ACC_W:FRAC_W];
  assign wsum  = {{2{w_q[W_W-1]}}, w_q} + {delta[ACC_W-FRAC_W], delta};
  assign w_ovf = !((wsum[W_W+1:W_W-1] == 3'b000) || (wsum[W_W+1:W_W-1] == 3'b111));

  always_comb begin
    if (w_ovf) begin
      wdata_o = wsum[W_W+1] ? W_MIN : W_MAX;
    end else begin
      wdata_o = wsum[W_W-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    if (ctrl_i.row_clr) begin
      acc_d = '0;
      sat_d = 1'b0;
    end else if (ctrl_i.upd) begin
      if (ctrl_i.corr) begin
        sat_d = sat_q | w_ovf;
      end else begin
        acc_d = acc_sat;
        sat_d = sat_q | acc_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// File: hw/rtl/perceptron_sum_and_update.sv
// flow: idle takes a beat and reads its weight from the one memory, mul multiplies, upd
// adds the product or writes the corrected weight back; a row's first beat passes mul and
// upd twice (bias, then feature weight), beats past the feature count go straight to done,
// and no beat is taken before idle; a row's last beat waits in done for a free output
// reset: async active low; clears control, sum and flags, restores learn_rate and bias_input
// defaults, and clears the weight valid bits so every weight reads zero at once
`default_nettype none
`include "perceptron_sum_and_update_defines.svh"

module perceptron_sum_and_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  psu_pkg::cfg_reg_e    cfg_idx_i,
  input  logic [15:0]          cfg_data_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // feature [15:0], error [31:16]
  input  logic [0:0]           s_axis_tuser,   // cmd [0]
  input  logic                 s_axis_tlast,   // row_last

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // weighted_sum [47:0]
  output logic [0:0]           m_axis_tuser    // saturated [0]
);
  import psu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e           state_d, state_q;
  logic [AW-1:0]    idx_d, idx_q;
  logic             bias_op_d, bias_op_q;

  logic [LR_W-1:0]  lr_q;
  logic [X_W-1:0]   bias_q;

  cmd_e             cmd_q;
  logic [X_W-1:0]   feat_q;
  logic             last_q;

  logic             m_valid_q;
  logic [ACC_W-1:0] sum_out_q;
  logic             sat_out_q;

  logic             s_acc;
  logic             out_load;
  logic [AW-1:0]    feat_addr;
  logic             re;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [W_W-1:0]   rdata;
  logic [W_W-1:0]   wdata;
  logic [X_W-1:0]   x_sel;
  logic [ACC_W-1:0] acc;
  logic             sat;
  dp_ctrl_t         ctrl;

  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign feat_addr     = idx_q + AW'(1);
  assign waddr         = bias_op_q ? '0 : feat_addr;
  assign x_sel         = bias_op_q ? bias_q : feat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= LEARN_RATE_RST;
      bias_q <= BIAS_INPUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEARN_RATE: lr_q   <= cfg_data_i;
        REG_BIAS_INPUT: bias_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q  <= cmd_e'(s_axis_tuser[0]);
      feat_q <= s_axis_tdata[X_W-1:0];
      last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    bias_op_d    = bias_op_q;
    re           = 1'b0;
    raddr        = feat_addr;
    we           = 1'b0;
    out_load     = 1'b0;
    ctrl         = '0;
    ctrl.corr    = (cmd_q == CMD_CORR);
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          ctrl.p1_load = 1'b1;
          if (idx_q == '0) begin
            // row start: bias weight first, then the first feature weight
            re        = 1'b1;
            raddr     = '0;
            bias_op_d = 1'b1;
            state_d   = S_MUL;
          end else if (idx_q != AW'(FEATURES)) begin
            re      = 1'b1;
            state_d = S_MUL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL: begin
        ctrl.mul = 1'b1;
        state_d  = S_UPD;
      end
      S_UPD: begin
        ctrl.upd = 1'b1;
        we       = ctrl.corr;
        if (bias_op_q) begin
          // feature entry differs from the bias entry being written
          bias_op_d = 1'b0;
          re        = 1'b1;
          state_d   = S_MUL;
        end else begin
          idx_d   = feat_addr;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!m_valid_q || m_axis_tready) begin
          out_load     = 1'b1;
          ctrl.row_clr = 1'b1;
          idx_d        = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      bias_op_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      bias_op_q <= bias_op_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_out_q <= acc;
      sat_out_q <= sat;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = sum_out_q;
  assign m_axis_tuser[0] = sat_out_q;

  psu_wmem u_wmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (re),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  psu_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .lr_i    (lr_q),
    .err_i   (s_axis_tdata[2*X_W-1:X_W]),
    .x_i     (x_sel),
    .w_i     (rdata),
    .wdata_o (wdata),
    .acc_o   (acc),
    .sat_o   (sat)
  );

  `PSU_ASSERT(a_idx_range, idx_q <= AW'(FEATURES))
  `PSU_ASSERT_IMP(a_bias_op_at_row_start, bias_op_q, idx_q == '0)
  `PSU_ASSERT_NEXT(a_row_clear, out_load, idx_q == '0 && acc == '0 && !sat)

endmodule

`default_nettype wire

// File: tb/tb_perceptron_sum_and_update.sv
`default_nettype none

module tb_perceptron_sum_and_update;
  timeunit 1ns;
  timeprecision 1ps;

  import psu_pkg::*;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint WT_HI  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WT_LO  = -WT_HI - 1;

  typedef struct packed {
    logic [47:0] sum;
    logic        sat;
  } row_result_t;

  class perceptron_scoreboard;
    logic [15:0]        learn_rate;
    logic signed [15:0] bias_in;
    longint             weight [FEATURES+1];
    int unsigned        pos;
    longint             acc;
    bit                 sat;
    row_result_t        row_results_q [$];
    int unsigned        errors;
    int unsigned        beats;
    int unsigned        results;
    int unsigned        sat_results;

    function new();
      learn_rate = LEARN_RATE_RST;
      bias_in    = BIAS_INPUT_RST;
      foreach (weight[i]) weight[i] = 0;
      pos = 0;
      acc = 0;
      sat = 1'b0;
      errors = 0;
      beats = 0;
      results = 0;
      sat_results = 0;
    endfunction

    function void set_regs(logic [15:0] lr, logic [15:0] bias);
      learn_rate = lr;
      bias_in    = bias;
    endfunction

    function void add_to_sum(longint p);
      longint s;
      s = acc + p;
      if (s > SUM_HI) begin
        s = SUM_HI;
        sat = 1'b1;
      end
      if (s < SUM_LO) begin
        s = SUM_LO;
        sat = 1'b1;
      end
      acc = s;
    endfunction

    // eta*err*x is Q16.32, round half up to Q16.16 then saturate
    function void correct_weight(int unsigned idx, longint err, longint x);
      longint term;
      longint w;
      term = longint'(learn_rate) * err * x;
      w = weight[idx] + ((term + 64'sd32768) >>> 16);
      if (w > WT_HI) begin
        w = WT_HI;
        sat = 1'b1;
      end
      if (w < WT_LO) begin
        w = WT_LO;
        sat = 1'b1;
      end
      weight[idx] = w;
    endfunction

    function void note_beat(cmd_e c, logic [15:0] f, logic [15:0] e, logic last);
      longint feat;
      longint err;
      row_result_t r;
      feat = longint'($signed(f));
      err  = longint'($signed(e));
      beats++;
      if (pos == 0) begin
        acc = 0;
        if (c == CMD_CORR) correct_weight(0, err, longint'(bias_in));
        else add_to_sum(longint'(bias_in) * weight[0]);
      end
      // beats past the feature count leave weights and sum alone
      if (pos < FEATURES) begin
        if (c == CMD_CORR) correct_weight(pos + 1, err, feat);
        else add_to_sum(feat * weight[pos+1]);
        pos++;
      end
      if (last) begin
        r.sum = acc[47:0];
        r.sat = sat;
        row_results_q.insert(row_results_q.size(), r);
        pos = 0;
        acc = 0;
        sat = 1'b0;
      end
    endfunction

    function void check_result(logic [47:0] sum, logic sat_o);
      row_result_t r;
      results++;
      if (sat_o) sat_results++;
      if (row_results_q.size() == 0) begin
        $error("unexpected result beat: weighted_sum %h saturated %b", sum, sat_o);
        errors++;
        return;
      end
      r = row_results_q.pop_front();
      if (sum !== r.sum) begin
        $error("weighted_sum mismatch: expected %h actual %h", r.sum, sum);
        errors++;
      end
      if (sat_o !== r.sat) begin
        $error("saturated mismatch: expected %b actual %b", r.sat, sat_o);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return row_results_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_reg_e    cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  perceptron_scoreboard sb = new();
  bit                   idle_on = 1'b1;
  bit                   hold_req = 1'b0;
  int unsigned          rows_sent = 0;

  always #5ns clk_i = ~clk_i;

  perceptron_sum_and_update u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // caller always sits just after a rising edge
  task automatic send_beat(input cmd_e c, input logic [15:0] f, input logic [15:0] e,
                           input logic last);
    while (idle_on && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e, f};
    s_axis_tuser  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(c, f, e, last);
  endtask

  function automatic logic [15:0] rand_q88();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4, 5: return 16'($signed($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_row(input int unsigned len, input int unsigned mode);
    cmd_e c;
    for (int i = 0; i < len; i++) begin
      if (mode == 2) c = cmd_e'($urandom_range(1));
      else if (mode == 1) c = CMD_CORR;
      else c = CMD_EVAL;
      send_beat(c, rand_q88(), rand_q88(), i == len - 1);
    end
    rows_sent++;
  endtask

  task automatic send_random_rows(input int unsigned n_beats);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    int unsigned mode;
    start = sb.beats;
    while (sb.beats - start < n_beats) begin
      r = $urandom_range(99);
      if (r < 65) len = FEATURES;
      else if (r < 78) len = $urandom_range(FEATURES - 1, 2);
      else if (r < 88) len = 1;
      else len = $urandom_range(FEATURES + 4, FEATURES + 1);
      r = $urandom_range(99);
      mode = (r < 40) ? 0 : (r < 80) ? 1 : 2;
      send_row(len, mode);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] lr, input logic [15:0] bias);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LEARN_RATE;
    cfg_data_i <= lr;
    @(posedge clk_i);
    cfg_idx_i  <= REG_BIAS_INPUT;
    cfg_data_i <= bias;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_regs(lr, bias);
  endtask

  // result side: checks each accepted beat and throttles tready
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 15);
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_LEARN_RATE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone beat rows: bias term only, then a bias and first weight update
    send_beat(CMD_EVAL, 16'h0000, 16'h0000, 1'b1);
    send_beat(CMD_CORR, 16'h8000, 16'h8000, 1'b1);
    // mixed commands within one row
    send_beat(CMD_CORR, 16'h7FFF, 16'h7FFF, 1'b0);
    send_beat(CMD_EVAL, 16'h7FFF, 16'h8000, 1'b0);
    send_beat(CMD_EVAL, 16'h8000, 16'h7FFF, 1'b1);
    send_beat(CMD_EVAL, 16'h8000, 16'h0000, 1'b1);
    // overlong row, the extra beats must not touch the sum
    for (int i = 0; i < FEATURES + 2; i++)
      send_beat(CMD_EVAL, (i % 2) ? 16'h8000 : 16'h7FFF, 16'hFFFF, i == FEATURES + 1);
    rows_sent += 5;
    s_axis_tvalid <= 1'b0;
    wait_drained();

    write_regs(16'hFFFF, 16'h8000);
    send_random_rows(160);
    wait_drained();

    // no idling on either side
    idle_on = 1'b0;
    write_regs(16'h0000, 16'h7FFF);
    send_random_rows(160);
    wait_drained();
    idle_on = 1'b1;

    // long receiver hold while the sender keeps offering beats
    write_regs(16'h0001, 16'hFFFF);
    hold_req = 1'b1;
    send_random_rows(160);
    wait_drained();

    write_regs(16'($urandom), 16'($urandom));
    send_random_rows(160);
    wait_drained();

    write_regs(LEARN_RATE_RST, BIAS_INPUT_RST);
    send_random_rows(160);
    wait_drained();

    write_regs(16'($urandom), 16'($urandom));
    send_random_rows(160);
    wait_drained();

    $display("covered %0d rows, %0d input beats, %0d result beats (%0d saturated)",
             rows_sent, sb.beats, sb.results, sb.sat_results);
    $display("register settings swept across learn rate and bias extremes, %0d errors",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
